// ----- src/shst_pkg.sv -----
`default_nettype none

package shst_pkg;

    localparam int HANDLE_W = 32;
    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int MARK_W   = 7;

    localparam logic [HANDLE_W-1:0] NO_HANDLE = '1;

    localparam logic [MODE_W-1:0] MODE_INSERT        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE_HANDLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE_SLOT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND          = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GET           = 3'd4;

    // The free-slot search looks at this many occupancy bits per cycle.
    localparam int SCAN_W     = 8;
    localparam int SCAN_SEL_W = 3;

    // Read address selection for the sorted entry memory.
    localparam logic [1:0] RD_MID  = 2'd0;
    localparam logic [1:0] RD_LO   = 2'd1;
    localparam logic [1:0] RD_PREV = 2'd2;
    localparam logic [1:0] RD_NEXT = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot_index;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [SLOT_W-1:0]   slot_out;
        logic [HANDLE_W-1:0] handle_out;
        logic [MARK_W-1:0]   high_water;
    } rsp_t;

    typedef struct packed {
        logic       capture;
        logic       hos_rd;
        logic       search_init;
        logic       key_victim;
        logic       step;
        logic       ent_rd;
        logic [1:0] ent_rd_sel;
        logic       scan_init;
        logic       scan_next;
        logic       take_free;
        logic       res_get;
        logic       res_hit;
        logic       release_slot;
        logic       ent_wr_shift;
        logic       ptr_dec;
        logic       ptr_inc;
        logic       commit_insert;
        logic       count_dec;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              key_invalid;
        logic              full;
        logic              idx_ok;
        logic              idx_used;
        logic              lo_lt_hi;
        logic              hit;
        logic              free_found;
        logic              shu_more;
        logic              shd_more;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- src/shst_ram.sv -----
`default_nettype none

module shst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/shst_ctrl.sv -----
`default_nettype none

module shst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  shst_pkg::sts_t      sts,
    output logic                req_ready,
    output shst_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_GET      = 4'd2;
    localparam logic [3:0] S_VICTIM   = 4'd3;
    localparam logic [3:0] S_SEARCH   = 4'd4;
    localparam logic [3:0] S_SCMP     = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_SHU      = 4'd8;
    localparam logic [3:0] S_SHU_WR   = 4'd9;
    localparam logic [3:0] S_SHD      = 4'd10;
    localparam logic [3:0] S_SHD_WR   = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.ent_rd_sel = shst_pkg::RD_MID;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                // The slot map is read for every transaction; only get and
                // remove by slot look at the data.
                cmd.hos_rd      = 1'b1;
                cmd.search_init = 1'b1;
                case (sts.mode)
                    shst_pkg::MODE_INSERT:
                    begin
                        state_next = (sts.key_invalid || sts.full) ? S_FINISH : S_SEARCH;
                    end
                    shst_pkg::MODE_REMOVE_HANDLE: state_next = S_SEARCH;
                    shst_pkg::MODE_FIND:          state_next = S_SEARCH;
                    shst_pkg::MODE_REMOVE_SLOT:
                    begin
                        state_next = sts.idx_ok ? S_VICTIM : S_FINISH;
                    end
                    shst_pkg::MODE_GET:           state_next = S_GET;
                    default:                      state_next = S_FINISH;
                endcase
            end
            S_GET:
            begin
                cmd.res_get = 1'b1;
                state_next  = S_FINISH;
            end
            S_VICTIM:
            begin
                if (sts.idx_used)
                begin
                    cmd.key_victim = 1'b1;
                    state_next     = S_SEARCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SEARCH:
            begin
                cmd.ent_rd = 1'b1;
                if (sts.lo_lt_hi)
                begin
                    cmd.ent_rd_sel = shst_pkg::RD_MID;
                    state_next     = S_SCMP;
                end
                else
                begin
                    cmd.ent_rd_sel = shst_pkg::RD_LO;
                    state_next     = S_CHECK;
                end
            end
            S_SCMP:
            begin
                cmd.step   = 1'b1;
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                case (sts.mode)
                    shst_pkg::MODE_INSERT:
                    begin
                        if (sts.hit)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    shst_pkg::MODE_FIND:
                    begin
                        cmd.res_hit = sts.hit;
                        state_next  = S_FINISH;
                    end
                    shst_pkg::MODE_REMOVE_HANDLE, shst_pkg::MODE_REMOVE_SLOT:
                    begin
                        if (sts.hit)
                        begin
                            cmd.res_hit      = 1'b1;
                            cmd.release_slot = 1'b1;
                            state_next       = S_SHD;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_SCAN:
            begin
                if (sts.free_found)
                begin
                    cmd.take_free = 1'b1;
                    state_next    = S_SHU;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SHU:
            begin
                if (sts.shu_more)
                begin
                    cmd.ent_rd     = 1'b1;
                    cmd.ent_rd_sel = shst_pkg::RD_PREV;
                    state_next     = S_SHU_WR;
                end
                else
                begin
                    cmd.commit_insert = 1'b1;
                    state_next        = S_FINISH;
                end
            end
            S_SHU_WR:
            begin
                cmd.ent_wr_shift = 1'b1;
                cmd.ptr_dec      = 1'b1;
                state_next       = S_SHU;
            end
            S_SHD:
            begin
                if (sts.shd_more)
                begin
                    cmd.ent_rd     = 1'b1;
                    cmd.ent_rd_sel = shst_pkg::RD_NEXT;
                    state_next     = S_SHD_WR;
                end
                else
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_SHD_WR:
            begin
                cmd.ent_wr_shift = 1'b1;
                cmd.ptr_inc      = 1'b1;
                state_next       = S_SHD;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/shst_dp.sv -----
`default_nettype none

module shst_dp #(
    parameter int SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  shst_pkg::req_t      req,
    input  shst_pkg::cmd_t      cmd,
    input  logic                rsp_ready,
    output shst_pkg::sts_t      sts,
    output logic                rsp_valid,
    output shst_pkg::rsp_t      rsp
);

    localparam int HW = shst_pkg::HANDLE_W;
    localparam int SW = shst_pkg::SLOT_W;
    localparam int MW = shst_pkg::MARK_W;
    localparam int GW = shst_pkg::SCAN_W;
    localparam int GS = shst_pkg::SCAN_SEL_W;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = HW + IW;
    localparam int NG = (SLOTS + GW - 1) / GW;
    localparam int GI = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW = NG * GW;
    localparam logic [CW-1:0] COUNT_FULL = CW'(SLOTS);

    // Control state.
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    mark_reg, mark_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Working registers of one transaction.
    shst_pkg::req_t   req_reg, req_next;
    logic [HW-1:0]    key_reg, key_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [GI-1:0]    grp_reg, grp_next;
    logic [IW-1:0]    free_reg, free_next;
    logic             res_ok_reg, res_ok_next;
    logic [IW-1:0]    res_slot_reg, res_slot_next;
    logic [HW-1:0]    res_hout_reg, res_hout_next;
    shst_pkg::rsp_t   rsp_reg, rsp_next;

    // Memory ports.
    logic [EW-1:0]    ent_rd_data;
    logic [IW-1:0]    ent_rd_addr;
    logic             ent_wr_en;
    logic [IW-1:0]    ent_wr_addr;
    logic [EW-1:0]    ent_wr_data;
    logic [HW-1:0]    hos_rd_data;

    logic [HW-1:0]    rd_handle;
    logic [IW-1:0]    rd_slot;
    logic [IW-1:0]    idx_addr;
    logic             idx_ok;
    logic             idx_used;
    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid;
    logic [CW:0]      ptr_up_w;
    logic [CW-1:0]    ptr_dn;
    logic [PW-1:0]    used_pad;
    logic [GW-1:0]    grp_bits;
    logic [GS-1:0]    free_sel;
    logic [IW-1:0]    free_cand;

    assign rd_handle = ent_rd_data[EW-1 -: HW];
    assign rd_slot   = ent_rd_data[IW-1:0];

    assign idx_addr = IW'(req_reg.slot_index);
    assign idx_ok   = (32'(req_reg.slot_index) < SLOTS);
    assign idx_used = idx_ok && used_reg[idx_addr];

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CW:1];
    assign ptr_up_w = {1'b0, ptr_reg} + (CW+1)'(1);
    assign ptr_dn   = ptr_reg - CW'(1);

    // Slots past the end of the table read as occupied, so the search
    // never settles on one of them.
    always_comb
    begin
        used_pad              = '1;
        used_pad[SLOTS-1:0]   = used_reg;
    end

    assign grp_bits = used_pad[grp_reg * GW +: GW];

    always_comb
    begin
        free_sel = '0;
        for (int k = GW - 1; k >= 0; k--)
        begin
            if (!grp_bits[k])
            begin
                free_sel = GS'(k);
            end
        end
    end

    assign free_cand = IW'({grp_reg, free_sel});

    always_comb
    begin
        sts.mode        = req_reg.mode;
        sts.key_invalid = (key_reg == shst_pkg::NO_HANDLE);
        sts.full        = (count_reg == COUNT_FULL);
        sts.idx_ok      = idx_ok;
        sts.idx_used    = idx_used;
        sts.lo_lt_hi    = (lo_reg < hi_reg);
        sts.hit         = (lo_reg < count_reg) && (rd_handle == key_reg);
        sts.free_found  = !(&grp_bits);
        sts.shu_more    = (ptr_reg > lo_reg);
        sts.shd_more    = (ptr_up_w < {1'b0, count_reg});
        sts.out_free    = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        case (cmd.ent_rd_sel)
            shst_pkg::RD_MID:  ent_rd_addr = mid[IW-1:0];
            shst_pkg::RD_LO:   ent_rd_addr = lo_reg[IW-1:0];
            shst_pkg::RD_PREV: ent_rd_addr = ptr_dn[IW-1:0];
            shst_pkg::RD_NEXT: ent_rd_addr = ptr_up_w[IW-1:0];
            default:           ent_rd_addr = mid[IW-1:0];
        endcase
    end

    assign ent_wr_en   = cmd.ent_wr_shift || cmd.commit_insert;
    assign ent_wr_addr = cmd.commit_insert ? lo_reg[IW-1:0] : ptr_reg[IW-1:0];
    assign ent_wr_data = cmd.commit_insert ? {key_reg, free_reg} : ent_rd_data;

    shst_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (cmd.ent_rd),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // A slot's handle is only meaningful while its occupancy bit is set.
    shst_ram #(
        .WIDTH (HW),
        .DEPTH (SLOTS)
    ) u_slot_map_ram (
        .clk     (clk),
        .wr_en   (cmd.commit_insert),
        .wr_addr (free_reg),
        .wr_data (key_reg),
        .rd_en   (cmd.hos_rd),
        .rd_addr (idx_addr),
        .rd_data (hos_rd_data)
    );

    always_comb
    begin
        count_next     = count_reg;
        mark_next      = mark_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        grp_next       = grp_reg;
        free_next      = free_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        res_hout_next  = res_hout_reg;
        rsp_next       = rsp_reg;

        if (cmd.capture)
        begin
            req_next      = req;
            key_next      = req.handle;
            res_ok_next   = 1'b0;
            res_slot_next = '0;
            res_hout_next = '0;
        end
        if (cmd.key_victim)
        begin
            key_next = hos_rd_data;
        end
        if (cmd.search_init)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd.step)
        begin
            if (rd_handle < key_reg)
            begin
                lo_next = mid + CW'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.scan_init)
        begin
            grp_next = '0;
        end
        if (cmd.scan_next)
        begin
            grp_next = grp_reg + GI'(1);
        end
        if (cmd.take_free)
        begin
            free_next = free_cand;
            ptr_next  = count_reg;
        end
        if (cmd.res_get)
        begin
            res_ok_next   = idx_ok;
            res_hout_next = idx_used ? hos_rd_data : shst_pkg::NO_HANDLE;
        end
        if (cmd.res_hit)
        begin
            res_ok_next   = 1'b1;
            res_slot_next = rd_slot;
        end
        if (cmd.release_slot)
        begin
            used_next[rd_slot] = 1'b0;
            res_hout_next      = key_reg;
            ptr_next           = lo_reg;
        end
        if (cmd.ptr_dec)
        begin
            ptr_next = ptr_dn;
        end
        if (cmd.ptr_inc)
        begin
            ptr_next = ptr_up_w[CW-1:0];
        end
        if (cmd.commit_insert)
        begin
            used_next[free_reg] = 1'b1;
            count_next          = count_reg + CW'(1);
            res_ok_next         = 1'b1;
            res_slot_next       = free_reg;
            if (mark_reg <= CW'(free_reg))
            begin
                mark_next = CW'(free_reg) + CW'(1);
            end
        end
        if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.out_load)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.ok         = res_ok_reg;
            rsp_next.slot_out   = SW'(res_slot_reg);
            rsp_next.handle_out = res_hout_reg;
            rsp_next.high_water = MW'(mark_reg);
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mark_reg      <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        ptr_reg      <= ptr_next;
        grp_reg      <= grp_next;
        free_reg     <= free_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        res_hout_reg <= res_hout_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every table entry owns exactly one occupied slot.
    a_used_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> ($countones(used_reg) == int'(count_reg)))
        else $error("slot occupancy disagrees with entry count");

    a_insert_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_insert |-> (!used_reg[free_reg] && (lo_reg <= count_reg)))
        else $error("insert takes an occupied slot or lands past the table end");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> ((count_reg <= COUNT_FULL) && (mark_reg <= COUNT_FULL)))
        else $error("entry count or high-water mark beyond the table size");

endmodule

`default_nettype wire

// ----- src/sorted_handle_slot_table_core.sv -----
`default_nettype none

// Channel  Dir  Payload           Transaction taken when
// req      in   shst_pkg::req_t   req_valid && req_ready
// rsp      out  shst_pkg::rsp_t   rsp_valid && rsp_ready
//
// One transaction at a time; req_ready is high only while the controller idles.
// A find is a binary search over the sorted entries; remove by slot first
// fetches the slot's handle. A remove then shifts later entries down, an insert
// scans for a free slot and shifts later entries up. Get and early refusals skip the search.
// The single read port of the sorted entry memory sets the search and shift pace.
// A finished result sits in the output register while the next request is taken.
// Reset clears the entry count, high-water mark and slot occupancy at once.

module sorted_handle_slot_table_core #(
    parameter int SLOTS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  shst_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output shst_pkg::rsp_t  rsp
);

    shst_pkg::cmd_t cmd;
    shst_pkg::sts_t sts;

    shst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    shst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
